// ===== src/gcl_pkg.sv =====
package gcl_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LW        = 32;                // level / edge word
  localparam int NW        = 104;               // signed numerator
  localparam int DW        = 67;                // unsigned denominator
  localparam int QW        = 32;                // quotient bits
  localparam int DIV_BITS  = 2;                 // quotient bits per divider stage
  localparam int DIV_STG   = QW / DIV_BITS;
  localparam int AW        = 51;                // summed advection term
  localparam int SW        = 52;                // full update sum
  localparam logic [15:0] DT_RESET = 16'd16384;

  typedef struct packed {
    logic signed [LW-1:0] level_c;
    logic signed [LW-1:0] level_w;
    logic signed [LW-1:0] level_e;
    logic signed [LW-1:0] level_n;
    logic signed [LW-1:0] level_s;
    logic signed [LW-1:0] level_nw;
    logic signed [LW-1:0] level_ne;
    logic signed [LW-1:0] level_sw;
    logic signed [LW-1:0] level_se;
    logic signed [LW-1:0] edge_stop;
    logic signed [LW-1:0] edge_grad_x;
    logic signed [LW-1:0] edge_grad_y;
  } in_t;

  typedef struct packed {
    logic signed [LW-1:0] new_level;
    logic                 kink_flag;
  } out_t;

  // per-pixel data carried alongside the curvature datapath
  typedef struct packed {
    logic signed [LW-1:0] c;
    logic signed [LW-1:0] g;
    logic signed [AW-1:0] adv;
    logic                 kink;
  } side_t;

endpackage

// ===== src/gcl_front.sv =====
module gcl_front
  import gcl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  in_t                  in_data,
  output logic                 out_vld,
  output logic signed [NW-1:0] out_num,
  output logic [DW-1:0]        out_den,
  output side_t                out_side
);

  // S1: differences
  logic                 s1_vld_r;
  logic signed [32:0]   a_r, b_r, dux_r, duy_r;
  logic signed [34:0]   uxx_r, uyy_r, q_r;
  logic signed [LW-1:0] c1_r, g1_r, gx_r, gy_r;
  logic                 k1_r;
  logic signed [32:0]   a_nxt, b_nxt, dux_nxt, duy_nxt;
  logic signed [34:0]   uxx_nxt, uyy_nxt, q_nxt;

  always_comb begin
    a_nxt   = 33'(in_data.level_e) - 33'(in_data.level_w);
    b_nxt   = 33'(in_data.level_s) - 33'(in_data.level_n);
    uxx_nxt = 35'(in_data.level_e) - (35'(in_data.level_c) <<< 1) + 35'(in_data.level_w);
    uyy_nxt = 35'(in_data.level_s) - (35'(in_data.level_c) <<< 1) + 35'(in_data.level_n);
    q_nxt   = 35'(in_data.level_se) - 35'(in_data.level_ne) - 35'(in_data.level_sw)
            + 35'(in_data.level_nw);
    // upwind choice by edge gradient sign
    if (in_data.edge_grad_x < 0) begin
      dux_nxt = 33'(in_data.level_e) - 33'(in_data.level_c);
    end else if (in_data.edge_grad_x > 0) begin
      dux_nxt = 33'(in_data.level_c) - 33'(in_data.level_w);
    end else begin
      dux_nxt = '0;
    end
    if (in_data.edge_grad_y < 0) begin
      duy_nxt = 33'(in_data.level_s) - 33'(in_data.level_c);
    end else if (in_data.edge_grad_y > 0) begin
      duy_nxt = 33'(in_data.level_c) - 33'(in_data.level_n);
    end else begin
      duy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    uxx_r <= uxx_nxt;
    uyy_r <= uyy_nxt;
    q_r   <= q_nxt;
    dux_r <= dux_nxt;
    duy_r <= duy_nxt;
    c1_r  <= in_data.level_c;
    g1_r  <= in_data.edge_stop;
    gx_r  <= in_data.edge_grad_x;
    gy_r  <= in_data.edge_grad_y;
    k1_r  <= (a_nxt == '0) && (b_nxt == '0);
  end

  // S2: squares and cross product, advection products
  logic                 s2_vld_r;
  logic signed [65:0]   aa_r, bb_r, ab_r;
  logic signed [64:0]   px_r, py_r;
  logic signed [34:0]   uxx2_r, uyy2_r, q2_r;
  logic signed [LW-1:0] c2_r, g2_r;
  logic                 k2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    aa_r   <= a_r * a_r;
    bb_r   <= b_r * b_r;
    ab_r   <= a_r * b_r;
    px_r   <= gx_r * dux_r;
    py_r   <= gy_r * duy_r;
    uxx2_r <= uxx_r;
    uyy2_r <= uyy_r;
    q2_r   <= q_r;
    c2_r   <= c1_r;
    g2_r   <= g1_r;
    k2_r   <= k1_r;
  end

  // S3: split partial products, denominator, advection sum
  logic                 s3_vld_r;
  logic signed [68:0]   p1lo_r, p2lo_r, p3lo_r;
  logic signed [67:0]   p1hi_r, p2hi_r, p3hi_r;
  logic [DW-1:0]        den3_r;
  side_t                side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    p1lo_r <= $signed({1'b0, aa_r[32:0]}) * uyy2_r;
    p1hi_r <= $signed(aa_r[65:33]) * uyy2_r;
    p2lo_r <= $signed({1'b0, ab_r[32:0]}) * q2_r;
    p2hi_r <= $signed(ab_r[65:33]) * q2_r;
    p3lo_r <= $signed({1'b0, bb_r[32:0]}) * uxx2_r;
    p3hi_r <= $signed(bb_r[65:33]) * uxx2_r;
    den3_r <= DW'(aa_r + bb_r) << 1;
    side3_r.c    <= c2_r;
    side3_r.g    <= g2_r;
    side3_r.adv  <= AW'(px_r >>> FRAC_BITS) + AW'(py_r >>> FRAC_BITS);
    side3_r.kink <= k2_r;
  end

  // S4: assemble the three products
  logic                 s4_vld_r;
  logic signed [NW-1:0] t1_r, t2_r, t3_r;
  logic [DW-1:0]        den4_r;
  side_t                side4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    t1_r    <= (NW'(p1hi_r) <<< 33) + NW'(p1lo_r);
    t2_r    <= (NW'(p2hi_r) <<< 33) + NW'(p2lo_r);
    t3_r    <= (NW'(p3hi_r) <<< 33) + NW'(p3lo_r);
    den4_r  <= den3_r;
    side4_r <= side3_r;
  end

  // S5: numerator 2*A*A*Uyy - A*B*Q + 2*B*B*Uxx
  logic                 s5_vld_r;
  logic signed [NW-1:0] num_r;
  logic [DW-1:0]        den5_r;
  side_t                side5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
    num_r   <= (t1_r <<< 1) - t2_r + (t3_r <<< 1);
    den5_r  <= den4_r;
    side5_r <= side4_r;
  end

  assign out_vld  = s5_vld_r;
  assign out_num  = num_r;
  assign out_den  = den5_r;
  assign out_side = side5_r;

endmodule

// ===== src/gcl_div.sv =====
module gcl_div
  import gcl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [NW-1:0] in_num,
  input  logic [DW-1:0]        in_den,
  input  side_t                in_side,
  output logic                 out_vld,
  output logic [QW-1:0]        out_quo,
  output logic                 out_ovf,
  output logic                 out_neg,
  output side_t                out_side
);

  localparam int HW = NW - 1 - QW;

  // D0: sign and magnitude
  logic            m_vld_r, m_neg_r;
  logic [NW-2:0]   mag_r;
  logic [DW-1:0]   m_den_r;
  side_t           m_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= in_vld;
    end
    m_neg_r  <= in_num[NW-1];
    mag_r    <= in_num[NW-1] ? (NW-1)'(-in_num) : (NW-1)'(in_num);
    m_den_r  <= in_den;
    m_side_r <= in_side;
  end

  // stage 0 holds the overflow check; stages 1..DIV_STG do the long division
  logic            vld_r  [DIV_STG+1];
  logic            neg_r  [DIV_STG+1];
  logic            ovf_r  [DIV_STG+1];
  logic [DW-1:0]   rem_r  [DIV_STG+1];
  logic [DW-1:0]   den_r  [DIV_STG+1];
  logic [QW-1:0]   low_r  [DIV_STG+1];
  logic [QW-1:0]   quo_r  [DIV_STG+1];
  side_t           side_r [DIV_STG+1];

  logic [DW-1:0]   rem_nxt [DIV_STG+1];
  logic [QW-1:0]   quo_nxt [DIV_STG+1];

  function automatic logic [DW:0] div_step(logic [DW-1:0] rem, logic nb, logic [DW-1:0] den);
    logic [DW:0] trial;
    trial = {rem, nb};
    if (trial >= {1'b0, den}) begin
      div_step = {1'b1, DW'(trial - {1'b0, den})};
    end else begin
      div_step = {1'b0, DW'(trial)};
    end
  endfunction

  always_comb begin
    logic [DW:0]   res;
    logic [DW-1:0] r;
    logic [QW-1:0] qv;
    logic [QW-1:0] lw;
    rem_nxt[0] = '0;
    quo_nxt[0] = '0;
    for (int k = 1; k <= DIV_STG; k++) begin
      r  = rem_r[k-1];
      qv = quo_r[k-1];
      lw = low_r[k-1];
      for (int j = 0; j < DIV_BITS; j++) begin
        res = div_step(r, lw[QW-1], den_r[k-1]);
        r   = res[DW-1:0];
        qv  = {qv[QW-2:0], res[DW]};
        lw  = lw << 1;
      end
      rem_nxt[k] = r;
      quo_nxt[k] = qv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STG; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= m_vld_r;
      for (int k = 1; k <= DIV_STG; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
    // quotient overflows 32 bits when the high part already reaches the divisor
    ovf_r[0]  <= mag_r[NW-2:QW] >= HW'(m_den_r);
    rem_r[0]  <= DW'(mag_r[NW-2:QW]);
    low_r[0]  <= mag_r[QW-1:0];
    quo_r[0]  <= '0;
    neg_r[0]  <= m_neg_r;
    den_r[0]  <= m_den_r;
    side_r[0] <= m_side_r;
    for (int k = 1; k <= DIV_STG; k++) begin
      ovf_r[k]  <= ovf_r[k-1];
      rem_r[k]  <= rem_nxt[k];
      low_r[k]  <= low_r[k-1] << DIV_BITS;
      quo_r[k]  <= quo_nxt[k];
      neg_r[k]  <= neg_r[k-1];
      den_r[k]  <= den_r[k-1];
      side_r[k] <= side_r[k-1];
    end
  end

  assign out_vld  = vld_r[DIV_STG];
  assign out_quo  = quo_r[DIV_STG];
  assign out_ovf  = ovf_r[DIV_STG];
  assign out_neg  = neg_r[DIV_STG];
  assign out_side = side_r[DIV_STG];

endmodule

// ===== src/gcl_back.sv =====
module gcl_back
  import gcl_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [QW-1:0] in_quo,
  input  logic          in_ovf,
  input  logic          in_neg,
  input  side_t         in_side,
  input  logic [15:0]   dt,
  output logic          out_vld,
  output out_t          out_data
);

  localparam logic [QW-1:0] MAG_CAP = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [LW-1:0] POS_MAX = {1'b0, {(LW-1){1'b1}}};
  localparam logic signed [LW-1:0] NEG_MIN = {1'b1, {(LW-1){1'b0}}};

  // B1: signed, saturated curvature term
  logic                 b1_vld_r;
  logic signed [LW-1:0] mc_r;
  side_t                b1_side_r;
  logic [QW-1:0]        mag;
  logic signed [LW-1:0] mc_nxt;

  always_comb begin
    mag = (in_ovf || in_quo > MAG_CAP) ? MAG_CAP : in_quo;
    if (in_side.kink) begin
      mc_nxt = '0;
    end else if (in_neg) begin
      mc_nxt = (mag == MAG_CAP) ? NEG_MIN : -$signed(mag);
    end else begin
      mc_nxt = mag[QW-1] ? POS_MAX : $signed(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
    end else begin
      b1_vld_r <= in_vld;
    end
    mc_r      <= mc_nxt;
    b1_side_r <= in_side;
  end

  // B2: g * curvature
  logic                 b2_vld_r;
  logic signed [63:0]   gm_r;
  side_t                b2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_vld_r <= 1'b0;
    end else begin
      b2_vld_r <= b1_vld_r;
    end
    gm_r      <= b1_side_r.g * mc_r;
    b2_side_r <= b1_side_r;
  end

  // B3: full update sum
  logic                 b3_vld_r;
  logic signed [SW-1:0] dus_r;
  side_t                b3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b3_vld_r <= 1'b0;
    end else begin
      b3_vld_r <= b2_vld_r;
    end
    dus_r     <= SW'(gm_r >>> FRAC_BITS) + SW'(b2_side_r.adv);
    b3_side_r <= b2_side_r;
  end

  // B4: scale by time step
  logic                 b4_vld_r;
  logic signed [SW+16:0] prod_r;
  side_t                b4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b4_vld_r <= 1'b0;
    end else begin
      b4_vld_r <= b3_vld_r;
    end
    prod_r    <= dus_r * $signed({1'b0, dt});
    b4_side_r <= b3_side_r;
  end

  // B5: add and saturate
  logic                 b5_vld_r;
  out_t                 res_r;
  logic signed [SW+1:0] nv;

  always_comb begin
    nv = (SW+2)'(b4_side_r.c) + (SW+2)'(prod_r >>> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b5_vld_r <= 1'b0;
    end else begin
      b5_vld_r <= b4_vld_r;
    end
    if (nv > (SW+2)'(POS_MAX)) begin
      res_r.new_level <= POS_MAX;
    end else if (nv < (SW+2)'(NEG_MIN)) begin
      res_r.new_level <= NEG_MIN;
    end else begin
      res_r.new_level <= LW'(nv);
    end
    res_r.kink_flag <= b4_side_r.kink;
  end

  assign out_vld  = b5_vld_r;
  assign out_data = res_r;

endmodule

// ===== src/geodesic_contour_level_update_top.sv =====
// A start beat passes through the front, divider and back pipelines to the out_valid strobe.
// Throughput: one pixel per cycle; busy is always low, the pipeline never stalls.
// The depth is set by the 16-stage restoring divider, two quotient bits per stage.
// Reset (rst_n low, synchronous) clears every valid bit and sets dt_r to 16384.
// The receiver cannot stall: each result is shown for exactly one cycle.
module geodesic_contour_level_update_top
  import gcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  output out_t        out_data
);

  // time step register, Q0.16
  logic [15:0] dt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= DT_RESET;
    end else if (cfg_we) begin
      dt_r <= cfg_wdata;
    end
  end

  // nothing ever holds the pipe, so a beat may enter every cycle
  assign busy = 1'b0;

  // front: differences, products, curvature numerator and denominator (5 stages)
  logic                 f_vld;
  logic signed [NW-1:0] f_num;
  logic [DW-1:0]        f_den;
  side_t                f_side;

  gcl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start),
    .in_data  (in_data),
    .out_vld  (f_vld),
    .out_num  (f_num),
    .out_den  (f_den),
    .out_side (f_side)
  );

  // divider: magnitude, overflow check, 16 long-division stages (18 stages)
  logic          d_vld, d_ovf, d_neg;
  logic [QW-1:0] d_quo;
  side_t         d_side;

  gcl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (f_vld),
    .in_num   (f_num),
    .in_den   (f_den),
    .in_side  (f_side),
    .out_vld  (d_vld),
    .out_quo  (d_quo),
    .out_ovf  (d_ovf),
    .out_neg  (d_neg),
    .out_side (d_side)
  );

  // back: curvature saturation, edge weighting, time step, final saturation (5 stages)
  gcl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (d_vld),
    .in_quo   (d_quo),
    .in_ovf   (d_ovf),
    .in_neg   (d_neg),
    .in_side  (d_side),
    .dt       (dt_r),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

endmodule
